// ===== rtl/md5_pkg.sv =====
package md5_pkg;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hEFCDAB89;
    localparam logic [31:0] IV_C = 32'h98BADCFE;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam int unsigned WORDS = 16;
    localparam logic [5:0] BLK_LAST = 6'd63;
    localparam logic [5:0] LEN_POS = 6'd56;
    localparam logic [5:0] RND_LAST = 6'd63;
    localparam logic [7:0] PAD_MARK = 8'h80;

    typedef struct packed {
        logic       absorb;
        logic       pad_start;
        logic       pad_write;
        logic       cinit;
        logic       round;
        logic       chain_add;
        logic       emit;
        logic [5:0] rnd;
    } md5_cmd_t;

    typedef struct packed {
        logic byte_full;
        logic pad_full;
        logic last_blk;
        logic out_busy;
    } md5_sts_t;

    function automatic logic [31:0] round_const(input logic [5:0] i);
        logic [31:0] k;
        begin
            unique case (i)
                6'd0:  k = 32'hD76AA478;
                6'd1:  k = 32'hE8C7B756;
                6'd2:  k = 32'h242070DB;
                6'd3:  k = 32'hC1BDCEEE;
                6'd4:  k = 32'hF57C0FAF;
                6'd5:  k = 32'h4787C62A;
                6'd6:  k = 32'hA8304613;
                6'd7:  k = 32'hFD469501;
                6'd8:  k = 32'h698098D8;
                6'd9:  k = 32'h8B44F7AF;
                6'd10: k = 32'hFFFF5BB1;
                6'd11: k = 32'h895CD7BE;
                6'd12: k = 32'h6B901122;
                6'd13: k = 32'hFD987193;
                6'd14: k = 32'hA679438E;
                6'd15: k = 32'h49B40821;
                6'd16: k = 32'hF61E2562;
                6'd17: k = 32'hC040B340;
                6'd18: k = 32'h265E5A51;
                6'd19: k = 32'hE9B6C7AA;
                6'd20: k = 32'hD62F105D;
                6'd21: k = 32'h02441453;
                6'd22: k = 32'hD8A1E681;
                6'd23: k = 32'hE7D3FBC8;
                6'd24: k = 32'h21E1CDE6;
                6'd25: k = 32'hC33707D6;
                6'd26: k = 32'hF4D50D87;
                6'd27: k = 32'h455A14ED;
                6'd28: k = 32'hA9E3E905;
                6'd29: k = 32'hFCEFA3F8;
                6'd30: k = 32'h676F02D9;
                6'd31: k = 32'h8D2A4C8A;
                6'd32: k = 32'hFFFA3942;
                6'd33: k = 32'h8771F681;
                6'd34: k = 32'h6D9D6122;
                6'd35: k = 32'hFDE5380C;
                6'd36: k = 32'hA4BEEA44;
                6'd37: k = 32'h4BDECFA9;
                6'd38: k = 32'hF6BB4B60;
                6'd39: k = 32'hBEBFBC70;
                6'd40: k = 32'h289B7EC6;
                6'd41: k = 32'hEAA127FA;
                6'd42: k = 32'hD4EF3085;
                6'd43: k = 32'h04881D05;
                6'd44: k = 32'hD9D4D039;
                6'd45: k = 32'hE6DB99E5;
                6'd46: k = 32'h1FA27CF8;
                6'd47: k = 32'hC4AC5665;
                6'd48: k = 32'hF4292244;
                6'd49: k = 32'h432AFF97;
                6'd50: k = 32'hAB9423A7;
                6'd51: k = 32'hFC93A039;
                6'd52: k = 32'h655B59C3;
                6'd53: k = 32'h8F0CCC92;
                6'd54: k = 32'hFFEFF47D;
                6'd55: k = 32'h85845DD1;
                6'd56: k = 32'h6FA87E4F;
                6'd57: k = 32'hFE2CE6E0;
                6'd58: k = 32'hA3014314;
                6'd59: k = 32'h4E0811A1;
                6'd60: k = 32'hF7537E82;
                6'd61: k = 32'hBD3AF235;
                6'd62: k = 32'h2AD7D2BB;
                6'd63: k = 32'hEB86D391;
            endcase
            return k;
        end
    endfunction

    function automatic logic [4:0] rot_amt(input logic [5:0] i);
        logic [4:0] s;
        begin
            unique case ({i[5:4], i[1:0]})
                4'd0:  s = 5'd7;
                4'd1:  s = 5'd12;
                4'd2:  s = 5'd17;
                4'd3:  s = 5'd22;
                4'd4:  s = 5'd5;
                4'd5:  s = 5'd9;
                4'd6:  s = 5'd14;
                4'd7:  s = 5'd20;
                4'd8:  s = 5'd4;
                4'd9:  s = 5'd11;
                4'd10: s = 5'd16;
                4'd11: s = 5'd23;
                4'd12: s = 5'd6;
                4'd13: s = 5'd10;
                4'd14: s = 5'd15;
                4'd15: s = 5'd21;
            endcase
            return s;
        end
    endfunction

    // message word index per round, mod 16
    function automatic logic [3:0] word_sel(input logic [5:0] i);
        logic [3:0] j;
        logic [3:0] g;
        begin
            j = i[3:0];
            unique case (i[5:4])
                2'd0: g = j;
                2'd1: g = j * 4'd5 + 4'd1;
                2'd2: g = j * 4'd3 + 4'd5;
                2'd3: g = j * 4'd7;
            endcase
            return g;
        end
    endfunction

endpackage

// ===== rtl/md5_ctrl.sv =====
module md5_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             byte_valid,
    input  logic             end_of_message,
    input  md5_pkg::md5_sts_t sts,
    output md5_pkg::md5_cmd_t cmd
);
    import md5_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PAD   = 6'b000010,
        ST_CINIT = 6'b000100,
        ST_ROUND = 6'b001000,
        ST_FINAL = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] rnd_reg, rnd_next;
    logic       end_pend_reg, end_pend_next;
    logic       pad_act_reg, pad_act_next;

    always_comb
    begin
        state_next    = state_reg;
        rnd_next      = rnd_reg;
        end_pend_next = end_pend_reg;
        pad_act_next  = pad_act_reg;
        in_ready      = 1'b0;
        cmd           = '0;
        cmd.rnd       = rnd_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.absorb = byte_valid;
                    if (byte_valid && sts.byte_full)
                    begin
                        end_pend_next = end_of_message;
                        state_next    = ST_CINIT;
                    end
                    else if (end_of_message)
                    begin
                        cmd.pad_start = 1'b1;
                        pad_act_next  = 1'b1;
                        state_next    = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                cmd.pad_write = 1'b1;
                if (sts.pad_full)
                    state_next = ST_CINIT;
            end
            ST_CINIT:
            begin
                cmd.cinit  = 1'b1;
                rnd_next   = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round = 1'b1;
                rnd_next  = rnd_reg + 6'd1;
                if (rnd_reg == RND_LAST)
                    state_next = ST_FINAL;
            end
            ST_FINAL:
            begin
                cmd.chain_add = 1'b1;
                if (sts.last_blk)
                    state_next = ST_DONE;
                else if (pad_act_reg)
                    state_next = ST_PAD;
                else if (end_pend_reg)
                begin
                    cmd.pad_start = 1'b1;
                    pad_act_next  = 1'b1;
                    end_pend_next = 1'b0;
                    state_next    = ST_PAD;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.emit     = 1'b1;
                    pad_act_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rnd_reg      <= '0;
            end_pend_reg <= 1'b0;
            pad_act_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rnd_reg      <= rnd_next;
            end_pend_reg <= end_pend_next;
            pad_act_reg  <= pad_act_next;
        end
    end

endmodule

// ===== rtl/md5_dp.sv =====
module md5_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        msg_byte,
    input  md5_pkg::md5_cmd_t cmd,
    output md5_pkg::md5_sts_t sts,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [31:0]       digest_a,
    output logic [31:0]       digest_b,
    output logic [31:0]       digest_c,
    output logic [31:0]       digest_d
);
    import md5_pkg::*;

    logic [31:0] buf_reg [WORDS];
    logic [31:0] ch_a_reg, ch_b_reg, ch_c_reg, ch_d_reg;
    logic [31:0] wa_reg, wb_reg, wc_reg, wd_reg;
    logic [31:0] pre_reg, pre_next;
    logic [63:0] len_reg, len_next;
    logic [5:0]  pad_pos_reg;
    logic        pad_first_reg;
    logic        two_blk_reg;
    logic        last_reg;
    logic        out_valid_reg;
    logic [31:0] dg_a_reg, dg_b_reg, dg_c_reg, dg_d_reg;

    logic [5:0]  wr_pos;
    logic [7:0]  wr_byte;
    logic        wr_en;
    logic [7:0]  pad_byte;
    logic [5:0]  k_idx;
    logic [31:0] w_rd;
    logic [31:0] f_val;
    logic [31:0] t_val;
    logic [63:0] rot_dbl;
    logic [31:0] b_new;

    assign len_next = cmd.absorb ? (len_reg + 64'd8) : len_reg;

    always_comb
    begin
        if (pad_first_reg)
            pad_byte = PAD_MARK;
        else if (!two_blk_reg && (pad_pos_reg >= LEN_POS))
            pad_byte = len_reg[{pad_pos_reg[2:0], 3'b000} +: 8];
        else
            pad_byte = 8'h00;
    end

    always_comb
    begin
        wr_en   = cmd.absorb | cmd.pad_write;
        wr_pos  = cmd.absorb ? len_reg[8:3] : pad_pos_reg;
        wr_byte = cmd.absorb ? msg_byte : pad_byte;
    end

    // one round per cycle; pre_reg carries a + w[g] + K for the round under way
    always_comb
    begin
        k_idx = cmd.round ? (cmd.rnd + 6'd1) : 6'd0;
        w_rd  = buf_reg[word_sel(k_idx)];
        case (cmd.rnd[5:4])
            2'd0:    f_val = (wb_reg & wc_reg) | (~wb_reg & wd_reg);
            2'd1:    f_val = (wb_reg & wd_reg) | (wc_reg & ~wd_reg);
            2'd2:    f_val = wb_reg ^ wc_reg ^ wd_reg;
            default: f_val = wc_reg ^ (wb_reg | ~wd_reg);
        endcase
        t_val    = pre_reg + f_val;
        rot_dbl  = {t_val, t_val} << rot_amt(cmd.rnd);
        b_new    = wb_reg + rot_dbl[63:32];
        pre_next = (cmd.round ? wd_reg : ch_a_reg) + w_rd + round_const(k_idx);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            buf_reg[wr_pos[5:2]][{wr_pos[1:0], 3'b000} +: 8] <= wr_byte;
        if (cmd.cinit)
        begin
            wa_reg  <= ch_a_reg;
            wb_reg  <= ch_b_reg;
            wc_reg  <= ch_c_reg;
            wd_reg  <= ch_d_reg;
            pre_reg <= pre_next;
        end
        else if (cmd.round)
        begin
            wa_reg  <= wd_reg;
            wb_reg  <= b_new;
            wc_reg  <= wb_reg;
            wd_reg  <= wc_reg;
            pre_reg <= pre_next;
        end
        if (cmd.emit)
        begin
            dg_a_reg <= ch_a_reg;
            dg_b_reg <= ch_b_reg;
            dg_c_reg <= ch_c_reg;
            dg_d_reg <= ch_d_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_a_reg      <= IV_A;
            ch_b_reg      <= IV_B;
            ch_c_reg      <= IV_C;
            ch_d_reg      <= IV_D;
            len_reg       <= '0;
            pad_pos_reg   <= '0;
            pad_first_reg <= 1'b0;
            two_blk_reg   <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
            begin
                ch_a_reg <= IV_A;
                ch_b_reg <= IV_B;
                ch_c_reg <= IV_C;
                ch_d_reg <= IV_D;
                len_reg  <= '0;
                last_reg <= 1'b0;
            end
            else
            begin
                len_reg <= len_next;
                if (cmd.chain_add)
                begin
                    ch_a_reg <= ch_a_reg + wa_reg;
                    ch_b_reg <= ch_b_reg + wb_reg;
                    ch_c_reg <= ch_c_reg + wc_reg;
                    ch_d_reg <= ch_d_reg + wd_reg;
                end
            end
            if (cmd.pad_start)
            begin
                pad_pos_reg   <= len_next[8:3];
                pad_first_reg <= 1'b1;
                two_blk_reg   <= (len_next[8:3] >= LEN_POS);
            end
            else if (cmd.pad_write)
            begin
                pad_pos_reg   <= pad_pos_reg + 6'd1;
                pad_first_reg <= 1'b0;
                if (pad_pos_reg == BLK_LAST)
                begin
                    if (two_blk_reg)
                        two_blk_reg <= 1'b0;
                    else
                        last_reg <= 1'b1;
                end
            end
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        sts.byte_full = (len_reg[8:3] == BLK_LAST);
        sts.pad_full  = (pad_pos_reg == BLK_LAST);
        sts.last_blk  = last_reg;
        sts.out_busy  = out_valid_reg & ~out_ready;
    end

    assign out_valid = out_valid_reg;
    assign digest_a  = dg_a_reg;
    assign digest_b  = dg_b_reg;
    assign digest_c  = dg_c_reg;
    assign digest_d  = dg_d_reg;

endmodule

// ===== rtl/md5_message_digest_core.sv =====
// MD5 digest engine, one message byte per input transfer.
// Input channel (in_valid/in_ready): msg_byte, byte_valid, end_of_message.
// A transfer with byte_valid appends msg_byte; a transfer with end_of_message
// (after its byte, if any) pads the message, finishes it and queues one digest.
// Output channel (out_valid/out_ready): digest_a..digest_d, one transfer per
// message, words least significant byte first.
// Input: a byte that does not end a 64-byte block is taken without a stall. The
// 64th byte of a block starts the compression (setup, 64 rounds of the single
// round unit, chaining add), and no further transfer is taken until it is done.
// End of message: padding writes fill the block buffer, one byte per cycle,
// from the end of the message to the end of the block, and a whole second
// block when the length spills into it; each padding block (one or two) is
// then compressed, and the digest register is loaded last.
// The digest register decouples the sides: the next message is taken while
// the digest waits. A second digest is held back (in_ready low) only until
// the receiver takes the first one.
// Reset clears the chaining words to the MD5 initial values, the bit length
// to zero and drops any pending digest; no clearing pass is needed.
module md5_message_digest_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  msg_byte,
    input  logic        byte_valid,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_a,
    output logic [31:0] digest_b,
    output logic [31:0] digest_c,
    output logic [31:0] digest_d
);
    import md5_pkg::*;

    md5_cmd_t cmd;
    md5_sts_t sts;

    md5_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .byte_valid     (byte_valid),
        .end_of_message (end_of_message),
        .sts            (sts),
        .cmd            (cmd)
    );

    md5_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_byte  (msg_byte),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .digest_a  (digest_a),
        .digest_b  (digest_b),
        .digest_c  (digest_c),
        .digest_d  (digest_d)
    );

`ifndef NO_ASSERTIONS
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !sts.out_busy)
        else $error("digest overwritten while output stalled");

    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.absorb, cmd.pad_write, cmd.cinit, cmd.round, cmd.chain_add,
                  cmd.emit}))
        else $error("conflicting datapath commands");

    a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.round && (cmd.rnd == RND_LAST)) |=> cmd.chain_add)
        else $error("chaining add missing after last round");

    a_busy_no_in: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.round || cmd.pad_write) |-> !in_ready)
        else $error("input taken during block processing");
`endif

endmodule
